FILE: design/stbpu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stbpu_pkg
// Shared types, constants and helper functions for the spanning tree
// bridge port update block.
// ----------------------------------------------------------------------------
package stbpu_pkg;

    // field widths
    localparam int LAN_W       = 3;
    localparam int ID_W        = 8;
    localparam int HOP_W       = 8;
    localparam int LAN_CNT_W   = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    // emission limit per message and default number of lan slots
    localparam int OUT_LIMIT    = 8;
    localparam int DEF_MAX_LANS = 8;

    // hop count ceiling
    localparam logic [HOP_W-1:0] HOP_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAN_COUNT = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } t_state;

    // comparison outcome
    typedef enum logic [1:0] {
        CMP_NONE   = 2'd0,
        CMP_ROOT   = 2'd1,
        CMP_BRIDGE = 2'd2,
        CMP_HOP    = 2'd3
    } t_cmp;

    // one stored lan entry
    typedef struct packed {
        logic [ID_W-1:0]  root;
        logic [HOP_W-1:0] hop;
        logic             designated;
    } t_lan_entry;

    // one emitted message from the sequencer
    typedef struct packed {
        logic [LAN_W-1:0] lan;
        logic [ID_W-1:0]  root;
        logic [HOP_W-1:0] hop;
        t_cmp             res;
        logic             last;
    } t_emit;

    // saturating hop increment
    function automatic logic [HOP_W-1:0] hop_inc(input logic [HOP_W-1:0] h);
        hop_inc = (h == HOP_MAX) ? HOP_MAX : h + 1'b1;
    endfunction

    // compare received message against a stored one, first match wins
    function automatic t_cmp judge(
        input logic [ID_W-1:0]  s_root,
        input logic [HOP_W-1:0] s_hop,
        input logic [ID_W-1:0]  r_root,
        input logic [HOP_W-1:0] r_hop,
        input logic [ID_W-1:0]  r_sender,
        input logic [ID_W-1:0]  own_id
    );
        priority if (r_root < s_root) begin
            judge = CMP_ROOT;
        end else if (r_root == s_root && r_hop == s_hop && r_sender < own_id) begin
            judge = CMP_BRIDGE;
        end else if (r_root == s_root && r_hop < s_hop) begin
            judge = CMP_HOP;
        end else begin
            judge = CMP_NONE;
        end
    endfunction

endpackage
`default_nettype wire

FILE: design/stbpu_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stbpu_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module stbpu_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: design/stbpu_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stbpu_core
// Message sequencer: reads the arrival lan entry, compares, updates the bridge
// state and lan table, then walks the lans emitting one message per unskipped lan.
// ----------------------------------------------------------------------------
module stbpu_core #(
    parameter int MAX_LANS = stbpu_pkg::DEF_MAX_LANS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // message input
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [stbpu_pkg::LAN_W-1:0]     i_arrival_lan,
    input  wire logic [stbpu_pkg::ID_W-1:0]      i_root_id,
    input  wire logic [stbpu_pkg::HOP_W-1:0]     i_hop_count,
    input  wire logic [stbpu_pkg::ID_W-1:0]      i_sender_id,
    // configuration view
    input  wire logic [stbpu_pkg::ID_W-1:0]      i_own_id,
    input  wire logic                            i_own_wr,
    input  wire logic [stbpu_pkg::ID_W-1:0]      i_own_data,
    input  wire logic [stbpu_pkg::LAN_CNT_W-1:0] i_lan_n,
    // emitted messages
    output logic                                 o_emit_valid,
    input  wire logic                            i_emit_ready,
    output stbpu_pkg::t_emit                     o_emit
);
    import stbpu_pkg::*;

    localparam int AW = (MAX_LANS > 1) ? $clog2(MAX_LANS) : 1;
    localparam int EW = $bits(t_lan_entry);

    // control state
    t_state                r_state, n_state;
    logic                  r_fwd;
    logic                  r_root_flag;
    logic [ID_W-1:0]       r_best_root;
    logic [HOP_W-1:0]      r_best_hop;
    logic [ID_W-1:0]       r_init_root;
    logic [MAX_LANS-1:0]   r_valid;
    logic [LAN_CNT_W-1:0]  r_k;
    logic                  r_sweep;
    logic                  r_arr_ok;
    t_cmp                  r_res;

    // captured message
    logic [LAN_W-1:0]      r_arr;
    logic [ID_W-1:0]       r_root;
    logic [HOP_W-1:0]      r_hop;
    logic [ID_W-1:0]       r_sender;

    // ram interface
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    t_lan_entry            ram_wentry;
    logic                  ram_re;
    logic [EW-1:0]         ram_rdata;
    t_lan_entry            rd_entry;

    // lookup stage signals
    logic                  accept;
    logic                  arr_ok;
    logic [AW-1:0]         arr_idx;
    logic [AW-1:0]         k_idx;
    logic [ID_W-1:0]       ent_root;
    logic [HOP_W-1:0]      ent_hop;
    logic                  ent_des;
    t_cmp                  res_best;
    t_cmp                  res;
    logic                  local_wr;

    // emit stage signals
    logic                  skip;
    logic                  skip_next;
    logic                  last_k;
    logic                  step;
    logic [LAN_CNT_W-1:0]  k_plus1;
    logic [LAN_CNT_W-1:0]  k_plus2;

    stbpu_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_LANS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wentry),
        .i_re    (ram_re),
        .i_raddr (AW'(i_arrival_lan)),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_lan_entry'(ram_rdata);
    assign accept   = i_in_valid && o_in_ready;
    assign arr_idx  = AW'(r_arr);
    assign k_idx    = AW'(r_k);
    assign arr_ok   = {1'b0, r_arr} < i_lan_n;

    // entry never written reads as its reset contents
    always_comb begin
        if (r_valid[arr_idx]) begin
            ent_root = rd_entry.root;
            ent_hop  = rd_entry.hop;
            ent_des  = rd_entry.designated;
        end else begin
            ent_root = r_init_root;
            ent_hop  = '0;
            ent_des  = 1'b1;
        end
    end

    // compare against best message first, then the arrival lan entry
    always_comb begin
        res_best = judge(r_best_root, r_best_hop, r_root, r_hop, r_sender, i_own_id);
        if (res_best == CMP_ROOT) begin
            res = CMP_ROOT;
        end else if (arr_ok) begin
            res = judge(ent_root, ent_hop, r_root, r_hop, r_sender, i_own_id);
        end else begin
            res = CMP_NONE;
        end
    end

    assign local_wr = (res == CMP_BRIDGE || res == CMP_HOP) && !r_root_flag
                      && arr_ok && ent_des;

    // lan walk bookkeeping
    assign k_plus1   = r_k + 1'b1;
    assign k_plus2   = r_k + 2'd2;
    assign skip      = r_fwd && r_arr_ok && (r_k == {1'b0, r_arr});
    assign skip_next = r_fwd && r_arr_ok && (k_plus1 == {1'b0, r_arr});
    assign last_k    = (k_plus1 == i_lan_n);
    assign step      = (r_state == ST_EMIT) && (skip || i_emit_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                n_state = (i_lan_n == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (step && last_k) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs and ram control
    always_comb begin
        o_in_ready   = 1'b0;
        o_emit_valid = 1'b0;
        ram_re       = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = arr_idx;
        ram_wentry   = '{root: r_root, hop: hop_inc(r_hop), designated: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                ram_re     = i_in_valid;
            end
            ST_LOOKUP: begin
                ram_we = local_wr;
            end
            ST_EMIT: begin
                o_emit_valid = !skip;
                ram_we       = r_sweep && step;
                ram_waddr    = k_idx;
                ram_wentry   = '{root: r_best_root, hop: r_best_hop, designated: 1'b1};
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // emitted message payload
    always_comb begin
        o_emit.lan  = r_k[LAN_W-1:0];
        o_emit.root = r_fwd ? r_root : r_best_root;
        o_emit.hop  = r_fwd ? hop_inc(r_hop) : r_best_hop;
        o_emit.res  = r_res;
        o_emit.last = last_k || ((k_plus2 == i_lan_n) && skip_next);
    end

    // message capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_arr    <= i_arrival_lan;
            r_root   <= i_root_id;
            r_hop    <= i_hop_count;
            r_sender <= i_sender_id;
        end
    end

    // bridge state and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fwd       <= 1'b0;
            r_root_flag <= 1'b1;
            r_best_root <= '0;
            r_best_hop  <= '0;
            r_init_root <= '0;
            r_valid     <= '0;
            r_k         <= '0;
            r_sweep     <= 1'b0;
            r_arr_ok    <= 1'b0;
            r_res       <= CMP_NONE;
        end else begin
            r_state <= n_state;
            if (r_state == ST_LOOKUP) begin
                r_res    <= res;
                r_arr_ok <= arr_ok;
                r_k      <= '0;
                r_sweep  <= (res == CMP_ROOT);
                if (res == CMP_ROOT) begin
                    r_fwd       <= 1'b1;
                    r_root_flag <= 1'b0;
                    r_best_root <= r_root;
                    r_best_hop  <= hop_inc(r_hop);
                end
                if (local_wr) begin
                    r_valid[arr_idx] <= 1'b1;
                end
            end else if (step) begin
                r_k <= k_plus1;
                if (r_sweep) begin
                    r_valid[k_idx] <= 1'b1;
                end
            end else if (i_own_wr && r_root_flag) begin
                // own id also reloads best root and lan defaults until a root is adopted
                r_best_root <= i_own_data;
                r_init_root <= i_own_data;
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/spanning_tree_bridge_port_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spanning_tree_bridge_port_update
// Bridge message processing: compare, update lan table, emit per-lan messages.
// ----------------------------------------------------------------------------
// Usage:
//   A received message enters on the input channel (i_in_valid / o_in_ready).
//   For each message the block emits one transaction per attached lan on the
//   output channel (o_out_valid / i_out_ready); in forward mode the arrival
//   lan is skipped, and o_last marks the final transaction of the message.
//   Own id and lan count are written through i_cfg_we with no wait; the user
//   must write only while no message is in flight, as the block has no check.
// Sequence:
//   the accept cycle reads the message's lan entry from the lan table RAM,
//   the lookup state compares and updates, then the lan walk steps one lan
//   per cycle while the output does not stall. The single RAM write port
//   also copies a new root into every lan during the walk, and each result
//   is held in the output register before it reaches the port.
// Reset and stall:
//   synchronous active low reset clears all bridge state; the lan table needs
//   no clearing pass, since per-lan valid flags make unwritten entries read
//   as their reset contents. A stalled receiver holds the output register
//   and freezes the lan walk; the next message is accepted once the walk ends.
// ----------------------------------------------------------------------------
module spanning_tree_bridge_port_update #(
    parameter int MAX_LANS = stbpu_pkg::DEF_MAX_LANS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // message input
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [stbpu_pkg::LAN_W-1:0]      i_arrival_lan,
    input  wire logic [stbpu_pkg::ID_W-1:0]       i_root_id,
    input  wire logic [stbpu_pkg::HOP_W-1:0]      i_hop_count,
    input  wire logic [stbpu_pkg::ID_W-1:0]       i_sender_id,
    // message output
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic      [stbpu_pkg::LAN_W-1:0]      o_out_lan,
    output logic      [stbpu_pkg::ID_W-1:0]       o_out_root,
    output logic      [stbpu_pkg::HOP_W-1:0]      o_out_hop,
    output logic      [stbpu_pkg::ID_W-1:0]       o_out_sender,
    output logic      [1:0]                       o_compare_result,
    output logic                                  o_last,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [stbpu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [stbpu_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import stbpu_pkg::*;

    localparam int LAN_CAP = (MAX_LANS < OUT_LIMIT) ? MAX_LANS : OUT_LIMIT;

    // configuration registers
    logic [ID_W-1:0]      r_own_id;
    logic [LAN_CNT_W-1:0] r_lan_count;
    logic [LAN_CNT_W-1:0] lan_n;
    logic                 own_wr;

    // sequencer to output register
    logic                 emit_valid;
    logic                 emit_ready;
    t_emit                emit;

    // output register
    logic                 r_out_valid;
    t_emit                r_out;
    logic [ID_W-1:0]      r_out_sender;

    // configuration writes
    assign own_wr = i_cfg_we && (i_cfg_index == CFG_OWN_ID);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id    <= '0;
            r_lan_count <= LAN_CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OWN_ID:    r_own_id    <= i_cfg_data[ID_W-1:0];
                CFG_LAN_COUNT: r_lan_count <= i_cfg_data[LAN_CNT_W-1:0];
                default:       r_own_id    <= r_own_id;
            endcase
        end
    end

    // effective lan count, clamped to the table size and the emission limit
    assign lan_n = (r_lan_count > LAN_CNT_W'(LAN_CAP)) ? LAN_CNT_W'(LAN_CAP) : r_lan_count;

    stbpu_core #(
        .MAX_LANS (MAX_LANS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_arrival_lan (i_arrival_lan),
        .i_root_id     (i_root_id),
        .i_hop_count   (i_hop_count),
        .i_sender_id   (i_sender_id),
        .i_own_id      (r_own_id),
        .i_own_wr      (own_wr),
        .i_own_data    (i_cfg_data[ID_W-1:0]),
        .i_lan_n       (lan_n),
        .o_emit_valid  (emit_valid),
        .i_emit_ready  (emit_ready),
        .o_emit        (emit)
    );

    // output register, refilled in the cycle it is taken
    assign emit_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_ready) begin
            r_out_valid <= emit_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_ready && emit_valid) begin
            r_out        <= emit;
            r_out_sender <= r_own_id;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_lan        = r_out.lan;
    assign o_out_root       = r_out.root;
    assign o_out_hop        = r_out.hop;
    assign o_out_sender     = r_out_sender;
    assign o_compare_result = r_out.res;
    assign o_last           = r_out.last;

`ifndef SYNTHESIS
    // an accepted message keeps the input closed during compare
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input reopened right after a message was accepted");

    // emitted lan stays inside the configured lan count
    a_lan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_out_lan} < r_lan_count))
        else $error("emitted lan beyond the configured lan count");

    // every emitted message carries this bridge as sender
    a_sender_own: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_sender == r_own_id))
        else $error("emitted sender differs from own bridge id");
`endif

endmodule
`default_nettype wire

FILE: verif/spanning_tree_bridge_port_update_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spanning_tree_bridge_port_update_tb
// Self-checking bench for the bridge message update block. A short directed
// table exercises the comparison outcomes, hop saturation, out-of-range
// arrival LANs and LAN counts of zero, one and above the limit. Random
// messages follow, built around the bridge's current best message so that
// root adoption and LAN updates keep happening. Every emitted transaction is
// checked field by field against an in-bench model of the bridge state.
// ----------------------------------------------------------------------------
module spanning_tree_bridge_port_update_tb;
    import stbpu_pkg::*;

    localparam int LAN_SLOTS    = DEF_MAX_LANS;
    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int N_PHASES     = 6;
    localparam int PHASE_ITEMS  = 80;

    typedef enum logic {ROW_MSG, ROW_CFG} t_row_kind;

    // one directed step: a register write or a message
    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_data;
        logic [LAN_W-1:0]     lan;
        logic [ID_W-1:0]      root;
        logic [HOP_W-1:0]     hop;
        logic [ID_W-1:0]      sender;
        logic                 fixed;
        t_cmp                 want;
    } t_stim_row;

    // one emitted bridge message
    typedef struct {
        logic [LAN_W-1:0] lan;
        logic [ID_W-1:0]  root;
        logic [HOP_W-1:0] hop;
        logic [ID_W-1:0]  sender;
        t_cmp             cmp;
        logic             last;
    } t_bridge_msg;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  i_in_valid    = 1'b0;
    logic                  o_in_ready;
    logic [LAN_W-1:0]      i_arrival_lan = '0;
    logic [ID_W-1:0]       i_root_id     = '0;
    logic [HOP_W-1:0]      i_hop_count   = '0;
    logic [ID_W-1:0]       i_sender_id   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready   = 1'b0;
    logic [LAN_W-1:0]      o_out_lan;
    logic [ID_W-1:0]       o_out_root;
    logic [HOP_W-1:0]      o_out_hop;
    logic [ID_W-1:0]       o_out_sender;
    logic [1:0]            o_compare_result;
    logic                  o_last;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // bridge model state
    logic [ID_W-1:0]  own_id;
    logic [3:0]       lan_cnt;
    logic             fwd_mode;
    logic             root_flag;
    logic [ID_W-1:0]  best_root;
    logic [HOP_W-1:0] best_hop;
    logic [ID_W-1:0]  lan_root [LAN_SLOTS];
    logic [HOP_W-1:0] lan_hop  [LAN_SLOTS];
    logic             lan_desig [LAN_SLOTS];

    t_bridge_msg expected_msgs [$];

    // run bookkeeping
    int  mismatch_count  = 0;
    int  message_count   = 0;
    int  result_count    = 0;
    int  cfg_count       = 0;
    int  stall_cycles    = 0;
    int  outcome_tally [4] = '{0, 0, 0, 0};
    bit  steady_run      = 1'b0;
    bit  hold_output_req = 1'b0;

    always #5 i_clk = ~i_clk;

    spanning_tree_bridge_port_update u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_arrival_lan    (i_arrival_lan),
        .i_root_id        (i_root_id),
        .i_hop_count      (i_hop_count),
        .i_sender_id      (i_sender_id),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_lan        (o_out_lan),
        .o_out_root       (o_out_root),
        .o_out_hop        (o_out_hop),
        .o_out_sender     (o_out_sender),
        .o_compare_result (o_compare_result),
        .o_last           (o_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // bridge model
    // ------------------------------------------------------------------------

    function automatic logic [HOP_W-1:0] sat_hop(input logic [HOP_W-1:0] h);
        return (h == '1) ? h : h + 1'b1;
    endfunction

    function automatic int active_lans();
        int c = lan_cnt;
        if (c > LAN_SLOTS) c = LAN_SLOTS;
        if (c > OUT_LIMIT) c = OUT_LIMIT;
        return c;
    endfunction

    // received message against a stored one, first match wins
    function automatic t_cmp rank_against(
        input logic [ID_W-1:0]  s_root,
        input logic [HOP_W-1:0] s_hop,
        input logic [ID_W-1:0]  r_root,
        input logic [HOP_W-1:0] r_hop,
        input logic [ID_W-1:0]  r_sender
    );
        if (r_root < s_root)
            return CMP_ROOT;
        if (r_root == s_root && r_hop == s_hop && r_sender < own_id)
            return CMP_BRIDGE;
        if (r_root == s_root && r_hop < s_hop)
            return CMP_HOP;
        return CMP_NONE;
    endfunction

    function automatic void reset_bridge();
        own_id    = '0;
        lan_cnt   = 4'd1;
        fwd_mode  = 1'b0;
        root_flag = 1'b1;
        best_root = '0;
        best_hop  = '0;
        for (int k = 0; k < LAN_SLOTS; k++) begin
            lan_root[k]  = '0;
            lan_hop[k]   = '0;
            lan_desig[k] = 1'b1;
        end
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_OWN_ID) begin
            own_id = data[ID_W-1:0];
            // before any root is adopted the own id is also the best message
            if (root_flag) begin
                best_root = own_id;
                for (int k = 0; k < LAN_SLOTS; k++) lan_root[k] = own_id;
            end
        end else if (idx == CFG_LAN_COUNT) begin
            lan_cnt = data[3:0];
        end
    endfunction

    // update the bridge state for one message and queue what it emits
    function automatic void predict_message(
        input logic [LAN_W-1:0] lan,
        input logic [ID_W-1:0]  root,
        input logic [HOP_W-1:0] hop,
        input logic [ID_W-1:0]  sender,
        input logic             fixed,
        input t_cmp             want
    );
        int               n;
        int               total;
        int               sent;
        logic             in_range;
        t_cmp             res;
        logic [ID_W-1:0]  tx_root;
        logic [HOP_W-1:0] tx_hop;
        t_bridge_msg      msg;

        n = active_lans();
        in_range = (lan < n);
        res = rank_against(best_root, best_hop, root, hop, sender);
        if (res != CMP_ROOT)
            res = in_range ? rank_against(lan_root[lan], lan_hop[lan], root, hop, sender)
                           : CMP_NONE;

        // adopt a new root everywhere, or take a better path on this lan
        if (res == CMP_ROOT) begin
            fwd_mode  = 1'b1;
            root_flag = 1'b0;
            best_root = root;
            best_hop  = sat_hop(hop);
            for (int k = 0; k < n; k++) begin
                lan_root[k]  = best_root;
                lan_hop[k]   = best_hop;
                lan_desig[k] = 1'b1;
            end
        end else if ((res == CMP_BRIDGE || res == CMP_HOP) && !root_flag && in_range
                     && lan_desig[lan]) begin
            lan_root[lan]  = root;
            lan_hop[lan]   = sat_hop(hop);
            lan_desig[lan] = 1'b0;
        end

        tx_root = fwd_mode ? root : best_root;
        tx_hop  = fwd_mode ? sat_hop(hop) : best_hop;

        // one transaction per lan, arrival lan skipped when forwarding
        total = n - ((fwd_mode && in_range) ? 1 : 0);
        sent  = 0;
        for (int k = 0; k < n; k++) begin
            if (fwd_mode && in_range && k == lan) continue;
            msg.lan    = k[LAN_W-1:0];
            msg.root   = tx_root;
            msg.hop    = tx_hop;
            msg.sender = own_id;
            msg.cmp    = fixed ? want : res;
            msg.last   = (sent == total - 1);
            expected_msgs.push_back(msg);
            sent++;
        end
        outcome_tally[res]++;
        message_count++;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_stim_row msg_row(
        input logic [LAN_W-1:0] lan,
        input logic [ID_W-1:0]  root,
        input logic [HOP_W-1:0] hop,
        input logic [ID_W-1:0]  sender,
        input logic             fixed,
        input t_cmp             want
    );
        t_stim_row r;
        r.kind = ROW_MSG;
        r.cfg_idx = '0;
        r.cfg_data = '0;
        r.lan = lan;
        r.root = root;
        r.hop = hop;
        r.sender = sender;
        r.fixed = fixed;
        r.want = want;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row r;
        r = msg_row('0, '0, '0, '0, 1'b0, CMP_NONE);
        r.kind = ROW_CFG;
        r.cfg_idx = idx;
        r.cfg_data = data;
        return r;
    endfunction

    // wait until every queued transaction has come out, then let the block settle
    task automatic wait_drained();
        while (expected_msgs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_register(idx, data);
        cfg_count++;
    endtask

    // offer one message, wait for the transaction, then update the model
    task automatic offer_message(
        input logic [LAN_W-1:0] lan,
        input logic [ID_W-1:0]  root,
        input logic [HOP_W-1:0] hop,
        input logic [ID_W-1:0]  sender,
        input logic             fixed,
        input t_cmp             want
    );
        if (!steady_run && $urandom_range(3, 0) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(13, 1)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_arrival_lan <= lan;
        i_root_id     <= root;
        i_hop_count   <= hop;
        i_sender_id   <= sender;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_message(lan, root, hop, sender, fixed, want);
    endtask

    // random message built around the current best message, any root if wide_roots
    task automatic random_message(
        input  bit               wide_roots,
        output logic [LAN_W-1:0] lan,
        output logic [ID_W-1:0]  root,
        output logic [HOP_W-1:0] hop,
        output logic [ID_W-1:0]  sender
    );
        int               n;
        int               pick;
        logic [HOP_W-1:0] base_hop;

        n = active_lans();
        if (n > 0 && $urandom_range(99, 0) < 85)
            lan = LAN_W'($urandom_range(n - 1, 0));
        else
            lan = LAN_W'($urandom_range(7, 0));

        pick = $urandom_range(99, 0);
        if (wide_roots)
            root = ID_W'($urandom_range(255, 0));
        else if (pick < 8 && best_root > 0)
            root = best_root - ID_W'($urandom_range((best_root > 2) ? 2 : best_root, 1));
        else if (pick < 60)
            root = best_root;
        else if (pick < 75)
            root = lan_root[lan];
        else
            root = ID_W'($urandom_range(255, best_root));

        base_hop = (root == lan_root[lan] && $urandom_range(1, 0) == 1) ? lan_hop[lan]
                                                                         : best_hop;
        pick = $urandom_range(99, 0);
        if (pick < 35)
            hop = base_hop;
        else if (pick < 60 && base_hop > 0)
            hop = base_hop - 1'b1;
        else if (pick < 75)
            hop = sat_hop(base_hop);
        else
            hop = HOP_W'($urandom_range(255, 0));

        pick = $urandom_range(3, 0);
        if (pick < 2)
            sender = ID_W'($urandom_range(255, 0));
        else if (pick == 2 && own_id > 0)
            sender = own_id - 1'b1;
        else
            sender = own_id;
    endtask

    // ------------------------------------------------------------------------
    // output side: random back-pressure with one long hold-off
    // ------------------------------------------------------------------------
    initial begin : out_ready_drive
        int span;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_output_req) begin
                hold_output_req = 1'b0;
                i_out_ready <= 1'b0;
                for (span = 0; span < LONG_HOLD; span++) @(posedge i_clk);
            end else if (!steady_run && $urandom_range(4, 0) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(13, 1)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                span = steady_run ? 1 : $urandom_range(20, 1);
                repeat (span) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checking and watchdog
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_bridge_msg want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                result_count++;
                if (expected_msgs.size() == 0) begin
                    $error("unexpected transaction on lan %0d, root %0d, hop %0d",
                           o_out_lan, o_out_root, o_out_hop);
                    mismatch_count++;
                end else begin
                    want = expected_msgs.pop_front();
                    check_field("out_lan", want.lan, o_out_lan);
                    check_field("out_root", want.root, o_out_root);
                    check_field("out_hop", want.hop, o_out_hop);
                    check_field("out_sender", want.sender, o_out_sender);
                    check_field("compare_result", want.cmp, o_compare_result);
                    check_field("last", want.last, o_last);
                end
            end

            // no transaction for too long means the block is stuck
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_stim_row        directed_plan [$];
        t_stim_row        row;
        logic [ID_W-1:0]  phase_own [N_PHASES];
        logic [3:0]       phase_lans [N_PHASES];
        logic [LAN_W-1:0] lan;
        logic [ID_W-1:0]  root;
        logic [HOP_W-1:0] hop;
        logic [ID_W-1:0]  sender;

        reset_bridge();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: outcomes, saturation, out-of-range lans, lan count extremes
        directed_plan = '{
            cfg_row(CFG_OWN_ID, 8'hFA),
            cfg_row(CFG_LAN_COUNT, 8'h04),
            msg_row(3'd0, 8'hFF, 8'h00, 8'h00, 1'b1, CMP_NONE),
            msg_row(3'd1, 8'hFA, 8'h00, 8'hF9, 1'b1, CMP_BRIDGE),
            msg_row(3'd2, 8'hFA, 8'h00, 8'hFA, 1'b1, CMP_NONE),
            msg_row(3'd7, 8'hFA, 8'h00, 8'h00, 1'b1, CMP_NONE),
            msg_row(3'd3, 8'hF0, 8'hFF, 8'hFF, 1'b1, CMP_ROOT),
            msg_row(3'd0, 8'hF0, 8'hFE, 8'h55, 1'b1, CMP_HOP),
            msg_row(3'd1, 8'hF0, 8'hFF, 8'h00, 1'b1, CMP_BRIDGE),
            msg_row(3'd1, 8'hF0, 8'hFF, 8'h00, 1'b1, CMP_BRIDGE),
            msg_row(3'd2, 8'hF1, 8'h00, 8'h00, 1'b1, CMP_NONE),
            msg_row(3'd6, 8'hF0, 8'h00, 8'h00, 1'b1, CMP_NONE),
            cfg_row(CFG_LAN_COUNT, 8'hA1),
            msg_row(3'd0, 8'hF0, 8'h03, 8'h00, 1'b0, CMP_NONE),
            msg_row(3'd5, 8'hF0, 8'h10, 8'h00, 1'b1, CMP_NONE),
            cfg_row(CFG_LAN_COUNT, 8'h00),
            msg_row(3'd0, 8'hF0, 8'h00, 8'h00, 1'b0, CMP_NONE),
            cfg_row(CFG_OWN_ID, 8'hFF),
            cfg_row(CFG_LAN_COUNT, 8'h0F),
            msg_row(3'd7, 8'hF0, 8'hFF, 8'hFE, 1'b0, CMP_NONE),
            msg_row(3'd4, 8'hEF, 8'h00, 8'h12, 1'b1, CMP_ROOT),
            cfg_row(CFG_OWN_ID, 8'h00),
            msg_row(3'd2, 8'hEF, 8'h01, 8'h00, 1'b1, CMP_NONE),
            msg_row(3'd2, 8'hEF, 8'h00, 8'hAA, 1'b1, CMP_HOP)
        };
        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            if (row.kind == ROW_CFG)
                write_register(row.cfg_idx, row.cfg_data);
            else
                offer_message(row.lan, row.root, row.hop, row.sender, row.fixed, row.want);
        end

        // random phases, each with its own bridge id and lan count
        phase_own  = '{ID_W'($urandom_range(255, 0)), 8'hFF, ID_W'($urandom_range(255, 0)),
                       8'h00, ID_W'($urandom_range(255, 0)), ID_W'($urandom_range(255, 0))};
        phase_lans = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd5, 4'd8};
        for (int p = 0; p < N_PHASES; p++) begin
            write_register(CFG_OWN_ID, phase_own[p]);
            write_register(CFG_LAN_COUNT, {4'($urandom_range(15, 0)), phase_lans[p]});
            steady_run = (p == N_PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // fill the block behind a long output hold-off
                if (p == 0 && i == 20) hold_output_req = 1'b1;
                // sender pause until everything is out
                if (p == 1 && i == 30) begin
                    i_in_valid <= 1'b0;
                    wait_drained();
                end
                random_message(steady_run, lan, root, hop, sender);
                offer_message(lan, root, hop, sender, 1'b0, CMP_NONE);
            end
        end

        i_in_valid <= 1'b0;
        wait_drained();

        $display("run covered %0d messages, %0d result transactions, %0d register writes",
                 message_count, result_count, cfg_count);
        $display("outcomes: new root %0d, better bridge %0d, better hop %0d, none %0d",
                 outcome_tally[CMP_ROOT], outcome_tally[CMP_BRIDGE],
                 outcome_tally[CMP_HOP], outcome_tally[CMP_NONE]);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
design/stbpu_pkg.sv
design/stbpu_ram.sv
design/stbpu_core.sv
design/spanning_tree_bridge_port_update.sv
verif/spanning_tree_bridge_port_update_tb.sv
